// ===== rtl/rbd_pkg.sv =====
package rbd_pkg;

    // One input item: a byte of the batch and its end mark
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_item;

    // One result item per input byte
    typedef struct packed {
        logic [3:0]  byte_role;
        logic [30:0] record_index;
        logic        field_done;
        logic [63:0] field_value;
        logic        batch_end;
        logic [2:0]  status;
    } t_out_item;

    // Head of the intake queue as seen by the parser
    typedef struct packed {
        logic     valid;
        t_in_item item;
    } t_queue_head;

    // Parse phases; the encoding is also the byte role
    typedef enum logic [3:0] {
        PH_BASE   = 4'd0,
        PH_STAMP  = 4'd1,
        PH_COUNT  = 4'd2,
        PH_KEYLEN = 4'd3,
        PH_KEY    = 4'd4,
        PH_VALLEN = 4'd5,
        PH_VALUE  = 4'd6,
        PH_RSTAMP = 4'd7,
        PH_CRC    = 4'd8,
        PH_TRAIL  = 4'd9
    } t_phase;

    // Batch status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_SHORT     = 3'd1;
    localparam logic [2:0] ST_NO_KEYLEN = 3'd2;
    localparam logic [2:0] ST_KEY_OVER  = 3'd3;
    localparam logic [2:0] ST_VAL_OVER  = 3'd4;
    localparam logic [2:0] ST_NO_CRC    = 3'd5;
    localparam logic [2:0] ST_CRC_BAD   = 3'd6;
    localparam logic [2:0] ST_NEG_LEN   = 3'd7;

    // Shortest batch that can hold the fixed header and the CRC
    localparam logic [4:0] MIN_BATCH_BYTES = 5'd24;

    // Byte counter values at which a field completes (eight wraps to zero)
    localparam logic [2:0] FIELD_END_8 = 3'd0;
    localparam logic [2:0] FIELD_END_4 = 3'd4;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Advance a reflected CRC-32 by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/record_batch_deframer.sv =====
// An accepted byte is stored in the intake queue, then parsed into the output register.
// Throughput: one byte per cycle while the output is not stalled; the parser step
// (field counters plus one byte of CRC-32) is combinational.
// A two-entry intake queue lets input keep flowing while a result waits.
// Reset (i_rst_n low, synchronous) empties the queue and output register and
// returns the parser to the base offset phase with the CRC set to all ones.
module record_batch_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rbd_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output rbd_pkg::t_out_item o_out_item
);
    import rbd_pkg::*;

    t_queue_head head;
    logic        pop;

    // Front: take items into the queue
    rbd_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_pop      (pop),
        .o_head     (head)
    );

    // Back: walk the batch layout and register each result
    rbd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/rbd_fifo.sv =====
module rbd_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rbd_pkg::t_in_item    i_in_item,
    input  logic                 i_pop,
    output rbd_pkg::t_queue_head o_head
);
    import rbd_pkg::*;

    t_in_item   r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       push;

    assign o_in_ready  = (r_count != 2'd2);
    assign push        = i_in_valid && o_in_ready;
    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_slot[r_rd_ptr];

    // Store an incoming item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_in_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/rbd_parser.sv =====
module rbd_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rbd_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rbd_pkg::t_out_item   o_out_item
);
    import rbd_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_bif, n_bif;
    logic [63:0] r_shift, n_shift;
    logic [30:0] r_recs_left, n_recs_left;
    logic [30:0] r_pay_left, n_pay_left;
    logic [30:0] r_rec_num, n_rec_num;
    logic [31:0] r_crc, n_crc;
    logic [4:0]  r_seen, n_seen;
    logic [2:0]  r_err, n_err;
    logic        r_out_valid;
    t_out_item   r_out_item;
    t_out_item   n_out_item;

    logic [7:0]  b;
    logic        last;
    logic [63:0] shift_sum;
    logic [2:0]  bif_inc;
    logic [2:0]  field_end;
    logic [31:0] v32;
    logic [30:0] pay_dec;
    logic [30:0] recs_dec;
    logic        in_record;

    assign b    = i_head.item.data_byte;
    assign last = i_head.item.end_of_data;

    // Take the head item when the output register is free or being emptied
    assign o_pop       = i_head.valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    assign shift_sum = r_shift | ({56'd0, b} << {r_bif, 3'b000});
    assign bif_inc   = r_bif + 3'd1;
    assign v32       = shift_sum[31:0];
    assign pay_dec   = r_pay_left - 31'd1;
    assign recs_dec  = r_recs_left - 31'd1;
    assign in_record = (r_phase == PH_KEYLEN) || (r_phase == PH_KEY) ||
                       (r_phase == PH_VALLEN) || (r_phase == PH_VALUE) ||
                       (r_phase == PH_RSTAMP);
    assign field_end = ((r_phase == PH_BASE) || (r_phase == PH_STAMP) ||
                        (r_phase == PH_RSTAMP)) ? FIELD_END_8 : FIELD_END_4;

    // Phase register and parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BASE;
            r_bif       <= 3'd0;
            r_shift     <= 64'd0;
            r_recs_left <= 31'd0;
            r_pay_left  <= 31'd0;
            r_rec_num   <= 31'd0;
            r_crc       <= CRC_INIT;
            r_seen      <= 5'd0;
            r_err       <= ST_OK;
        end else if (o_pop) begin
            r_phase     <= n_phase;
            r_bif       <= n_bif;
            r_shift     <= n_shift;
            r_recs_left <= n_recs_left;
            r_pay_left  <= n_pay_left;
            r_rec_num   <= n_rec_num;
            r_crc       <= n_crc;
            r_seen      <= n_seen;
            r_err       <= n_err;
        end
    end

    // Output register: load on a taken item, drop once delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_item <= n_out_item;
        end
    end

    // Next parse state and result for the head byte
    always_comb begin
        n_phase     = r_phase;
        n_bif       = r_bif;
        n_shift     = r_shift;
        n_recs_left = r_recs_left;
        n_pay_left  = r_pay_left;
        n_rec_num   = r_rec_num;
        n_err       = r_err;
        n_seen      = (r_seen < MIN_BATCH_BYTES) ? r_seen + 5'd1 : r_seen;
        n_crc       = (r_phase <= PH_RSTAMP) ? crc_byte(r_crc, b) : r_crc;

        n_out_item              = '0;
        n_out_item.byte_role    = 4'(r_phase);
        n_out_item.record_index = in_record ? r_rec_num : 31'd0;
        n_out_item.batch_end    = last;

        unique case (r_phase) inside
            PH_KEY, PH_VALUE: begin
                n_pay_left = pay_dec;
                if (pay_dec == 31'd0) begin
                    n_phase = (r_phase == PH_KEY) ? PH_VALLEN : PH_RSTAMP;
                end
            end
            PH_BASE, PH_STAMP, PH_COUNT, PH_KEYLEN, PH_VALLEN, PH_RSTAMP, PH_CRC: begin
                n_shift = shift_sum;
                n_bif   = bif_inc;
                if (bif_inc == field_end) begin
                    n_out_item.field_done  = 1'b1;
                    n_out_item.field_value = shift_sum;
                    n_shift = 64'd0;
                    n_bif   = 3'd0;
                    if (r_phase == PH_BASE) begin
                        n_phase = PH_STAMP;
                    end else if (r_phase == PH_STAMP) begin
                        n_phase = PH_COUNT;
                    end else if (r_phase == PH_CRC) begin
                        if ((n_crc ^ CRC_INIT) != v32) begin
                            n_err = ST_CRC_BAD;
                        end
                        n_phase = PH_TRAIL;
                    end else if (r_phase != PH_RSTAMP && v32[31]) begin
                        // negative count or length: rest of batch is trailing
                        n_err   = ST_NEG_LEN;
                        n_phase = PH_TRAIL;
                    end else if (r_phase == PH_COUNT) begin
                        n_recs_left = v32[30:0];
                        n_rec_num   = 31'd0;
                        n_phase     = (v32[30:0] == 31'd0) ? PH_CRC : PH_KEYLEN;
                    end else if (r_phase == PH_KEYLEN) begin
                        if (v32[30:0] == 31'd0) begin
                            n_phase = PH_VALLEN;
                        end else begin
                            n_pay_left = v32[30:0];
                            n_phase    = PH_KEY;
                        end
                    end else if (r_phase == PH_VALLEN) begin
                        if (v32[30:0] == 31'd0) begin
                            n_phase = PH_RSTAMP;
                        end else begin
                            n_pay_left = v32[30:0];
                            n_phase    = PH_VALUE;
                        end
                    end else begin
                        // record timestamp closes the record
                        n_recs_left = recs_dec;
                        n_rec_num   = r_rec_num + 31'd1;
                        n_phase     = (recs_dec == 31'd0) ? PH_CRC : PH_KEYLEN;
                    end
                end
            end
            default: begin
                n_phase = PH_TRAIL;
            end
        endcase

        // Verdict on the end byte, then back to the reset state
        if (last) begin
            if (n_seen < MIN_BATCH_BYTES) begin
                n_out_item.status = ST_SHORT;
            end else if (n_err != ST_OK) begin
                n_out_item.status = n_err;
            end else begin
                unique case (n_phase) inside
                    PH_TRAIL:            n_out_item.status = ST_OK;
                    PH_KEYLEN:           n_out_item.status = ST_NO_KEYLEN;
                    PH_KEY, PH_VALLEN:   n_out_item.status = ST_KEY_OVER;
                    PH_VALUE, PH_RSTAMP: n_out_item.status = ST_VAL_OVER;
                    PH_CRC:              n_out_item.status = ST_NO_CRC;
                    default:             n_out_item.status = ST_SHORT;
                endcase
            end
            n_phase     = PH_BASE;
            n_bif       = 3'd0;
            n_shift     = 64'd0;
            n_recs_left = 31'd0;
            n_pay_left  = 31'd0;
            n_rec_num   = 31'd0;
            n_crc       = CRC_INIT;
            n_seen      = 5'd0;
            n_err       = ST_OK;
        end
    end

endmodule

// ===== rtl/rbd_checker.sv =====
module rbd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input rbd_pkg::t_in_item  i_in_item,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input rbd_pkg::t_out_item o_out_item
);
    import rbd_pkg::*;

    // Hold an offered item until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_item))
        else $error("input item changed while waiting");

    // Hold a stalled result unchanged
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    // Report a status only on the end byte
    a_status_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.batch_end |-> o_out_item.status == ST_OK)
        else $error("status on a non-end byte");

    // Show a field value only when a field completes
    a_value_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.field_done |-> o_out_item.field_value == 64'd0)
        else $error("field value without completed field");

    // Give a record number only inside a record
    a_rec_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.record_index != 31'd0 |->
            (o_out_item.byte_role == 4'(PH_KEYLEN) || o_out_item.byte_role == 4'(PH_KEY) ||
             o_out_item.byte_role == 4'(PH_VALLEN) || o_out_item.byte_role == 4'(PH_VALUE) ||
             o_out_item.byte_role == 4'(PH_RSTAMP)))
        else $error("record number outside a record");

endmodule

bind record_batch_deframer rbd_checker u_rbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ===== test/rbd_tb_pkg.sv =====
`timescale 1ns / 100ps

package rbd_tb_pkg;

    // Fold one byte into a reflected CRC-32, feeding the data a bit at a time, LSB first
    function automatic logic [31:0] crc32_step(input logic [31:0] crc_in, input logic [7:0] d);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ d[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ rbd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ===== test/record_batch_deframer_chk.sv =====
`timescale 1ns / 100ps

module record_batch_deframer_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  rbd_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  rbd_pkg::t_out_item i_out_item,
    output int                 o_fail_count,
    output int                 o_pending
);

    import rbd_pkg::*;

    // Parser state as the predictor tracks it
    t_phase      cur_phase;
    logic [2:0]  field_pos;
    logic [63:0] field_acc;
    logic [30:0] records_todo;
    logic [30:0] payload_todo;
    logic [30:0] rec_num;
    logic [31:0] crc_acc;
    logic [4:0]  seen_count;
    logic [2:0]  err_code;

    t_out_item   expected_results[$];
    t_out_item   predicted;
    t_out_item   want;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic reset_parser();
        cur_phase    = PH_BASE;
        field_pos    = '0;
        field_acc    = '0;
        records_todo = '0;
        payload_todo = '0;
        rec_num      = '0;
        crc_acc      = CRC_INIT;
        seen_count   = '0;
        err_code     = ST_OK;
    endtask

    // Work out the result of one byte and advance the parser
    task automatic deframe_byte(input t_in_item itm, output t_out_item res);
        t_phase      role;
        logic [30:0] rec;
        logic        done;
        logic [63:0] value;
        logic [2:0]  st;
        logic [2:0]  flen;
        logic [31:0] v32;
        role  = cur_phase;
        rec   = '0;
        done  = 1'b0;
        value = '0;
        st    = ST_OK;
        if (seen_count < MIN_BATCH_BYTES) begin
            seen_count = seen_count + 5'd1;
        end
        if (role >= PH_KEYLEN && role <= PH_RSTAMP) begin
            rec = rec_num;
        end
        if (role <= PH_RSTAMP) begin
            crc_acc = rbd_tb_pkg::crc32_step(crc_acc, itm.data_byte);
        end

        case (role)
            PH_KEY, PH_VALUE: begin
                payload_todo = payload_todo - 31'd1;
                if (payload_todo == '0) begin
                    cur_phase = (role == PH_KEY) ? PH_VALLEN : PH_RSTAMP;
                end
            end
            PH_TRAIL: begin
            end
            default: begin
                // Gather a fixed-size little-endian field
                flen = (role == PH_BASE || role == PH_STAMP || role == PH_RSTAMP) ?
                       FIELD_END_8 : FIELD_END_4;
                field_acc[field_pos*8 +: 8] = itm.data_byte;
                field_pos = field_pos + 3'd1;
                if (field_pos == flen) begin
                    v32       = field_acc[31:0];
                    done      = 1'b1;
                    value     = field_acc;
                    field_acc = '0;
                    field_pos = '0;
                    if (role == PH_BASE) begin
                        cur_phase = PH_STAMP;
                    end else if (role == PH_STAMP) begin
                        cur_phase = PH_COUNT;
                    end else if (role == PH_CRC) begin
                        if (~crc_acc != v32) begin
                            err_code = ST_CRC_BAD;
                        end
                        cur_phase = PH_TRAIL;
                    end else if (role != PH_RSTAMP && v32[31]) begin
                        // Negative count or length: give up on the rest of the batch
                        err_code  = ST_NEG_LEN;
                        cur_phase = PH_TRAIL;
                    end else if (role == PH_COUNT) begin
                        records_todo = v32[30:0];
                        rec_num      = '0;
                        cur_phase    = (v32[30:0] == '0) ? PH_CRC : PH_KEYLEN;
                    end else if (role == PH_KEYLEN) begin
                        payload_todo = v32[30:0];
                        cur_phase    = (v32 == '0) ? PH_VALLEN : PH_KEY;
                    end else if (role == PH_VALLEN) begin
                        payload_todo = v32[30:0];
                        cur_phase    = (v32 == '0) ? PH_RSTAMP : PH_VALUE;
                    end else begin
                        records_todo = records_todo - 31'd1;
                        rec_num      = rec_num + 31'd1;
                        cur_phase    = (records_todo == '0) ? PH_CRC : PH_KEYLEN;
                    end
                end
            end
        endcase

        // Verdict on the end byte, taken from where the parse stopped
        if (itm.end_of_data) begin
            if (seen_count < MIN_BATCH_BYTES) begin
                st = ST_SHORT;
            end else if (err_code != ST_OK) begin
                st = err_code;
            end else begin
                case (cur_phase)
                    PH_TRAIL:            st = ST_OK;
                    PH_KEYLEN:           st = ST_NO_KEYLEN;
                    PH_KEY, PH_VALLEN:   st = ST_KEY_OVER;
                    PH_VALUE, PH_RSTAMP: st = ST_VAL_OVER;
                    PH_CRC:              st = ST_NO_CRC;
                    default:             st = ST_SHORT;
                endcase
            end
        end

        res.byte_role    = role;
        res.record_index = rec;
        res.field_done   = done;
        res.field_value  = value;
        res.batch_end    = itm.end_of_data;
        res.status       = st;

        if (itm.end_of_data) begin
            reset_parser();
        end
    endtask

    task automatic note_mismatch(input string fld, input logic [63:0] exp_v,
                                 input logic [63:0] act_v);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
        o_fail_count = o_fail_count + 1;
    endtask

    // Watch both channels: retire results before queueing new predictions
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_parser();
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_out_item);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_item.byte_role !== want.byte_role)
                        note_mismatch("byte_role", 64'(want.byte_role),
                                      64'(i_out_item.byte_role));
                    if (i_out_item.record_index !== want.record_index)
                        note_mismatch("record_index", 64'(want.record_index),
                                      64'(i_out_item.record_index));
                    if (i_out_item.field_done !== want.field_done)
                        note_mismatch("field_done", 64'(want.field_done),
                                      64'(i_out_item.field_done));
                    if (i_out_item.field_value !== want.field_value)
                        note_mismatch("field_value", want.field_value, i_out_item.field_value);
                    if (i_out_item.batch_end !== want.batch_end)
                        note_mismatch("batch_end", 64'(want.batch_end),
                                      64'(i_out_item.batch_end));
                    if (i_out_item.status !== want.status)
                        note_mismatch("status", 64'(want.status), 64'(i_out_item.status));
                end
            end
            if (i_in_valid && i_in_ready) begin
                deframe_byte(i_in_item, predicted);
                expected_results = {expected_results, predicted};
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/record_batch_deframer_tb.sv =====
`timescale 1ns / 100ps

module record_batch_deframer_tb;

    import rbd_pkg::*;

    localparam int ITEM_TARGET  = 1700;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef enum int {
        BATCH_GOOD,
        BATCH_BAD_CRC,
        BATCH_CUT,
        BATCH_SHORT,
        BATCH_NEG,
        BATCH_NOISE
    } t_batch_kind;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_item;
    int        chk_fails;
    int        chk_pending;

    logic [7:0] batch_q[$];
    int         bytes_sent;
    int         cycle_count;

    record_batch_deframer dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_item (out_item)
    );

    record_batch_deframer_chk chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_item  (out_item),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idling phase from progress: none, sender idle, receiver stall, both
    function automatic int idle_phase();
        int p;
        p = bytes_sent * 4 / ITEM_TARGET;
        return (p > 3) ? 3 : p;
    endfunction

    function automatic int send_idle_pct();
        case (idle_phase())
            1:       return 73;
            3:       return 23;
            default: return 0;
        endcase
    endfunction

    function automatic int stall_pct();
        case (idle_phase())
            2:       return 73;
            3:       return 23;
            default: return 0;
        endcase
    endfunction

    task automatic push_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++) begin
            batch_q = {batch_q, v[i*8 +: 8]};
        end
    endtask

    task automatic push_rand(input int n);
        repeat (n) batch_q = {batch_q, 8'($urandom)};
    endtask

    // Close the batch with its CRC, optionally spoiled by one flipped bit
    task automatic append_crc(input bit spoil);
        logic [31:0] c;
        c = CRC_INIT;
        foreach (batch_q[i]) begin
            c = rbd_tb_pkg::crc32_step(c, batch_q[i]);
        end
        c = ~c;
        if (spoil) begin
            c[$urandom_range(31)] ^= 1'b1;
        end
        push_le({32'd0, c}, 4);
    endtask

    // Mostly short payloads, some empty, a few long
    function automatic logic [31:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 35) return 32'd0;
        if (r < 90) return 32'($urandom_range(1, 6));
        return 32'($urandom_range(7, 40));
    endfunction

    // Build one batch of the given kind into batch_q
    task automatic build_batch(input t_batch_kind kind);
        int          nrec;
        int          neg_field;
        int          field_no;
        bit          stop;
        logic [31:0] len;
        batch_q.delete();
        push_le({$urandom, $urandom}, 8);
        push_le({$urandom, $urandom}, 8);
        nrec      = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 2);
        neg_field = (kind == BATCH_NEG) ? $urandom_range(0, 2 * nrec) : -1;
        stop      = 1'b0;

        // Record count: negative, oversized (only when the batch is to be cut) or true
        if (neg_field == 0) begin
            push_le({33'd1, 31'($urandom)}, 4);
            stop = 1'b1;
        end else if (kind == BATCH_CUT && $urandom_range(3) == 0) begin
            push_le({33'd0, 31'($urandom)}, 4);
        end else begin
            push_le(64'(nrec), 4);
        end

        for (int r = 0; r < nrec && !stop; r++) begin
            for (int half = 0; half < 2 && !stop; half++) begin
                field_no = 2 * r + half + 1;
                if (field_no == neg_field) begin
                    push_le({33'd1, 31'($urandom)}, 4);
                    stop = 1'b1;
                end else if (kind == BATCH_CUT && $urandom_range(7) == 0) begin
                    // Huge length that the batch never fills
                    push_le({33'd0, 31'($urandom)}, 4);
                    push_rand($urandom_range(0, 12));
                    stop = 1'b1;
                end else begin
                    len = pick_len();
                    push_le({32'd0, len}, 4);
                    push_rand(len);
                end
            end
            if (!stop) begin
                push_le({$urandom, $urandom}, 8);
            end
        end

        if (kind == BATCH_NEG) begin
            push_rand($urandom_range(0, 6));
        end else if (!stop) begin
            append_crc(kind == BATCH_BAD_CRC);
            if (kind == BATCH_GOOD && $urandom_range(2) == 0) begin
                push_rand($urandom_range(1, 4));
            end
        end

        // Trim or replace for the broken kinds
        case (kind)
            BATCH_CUT: begin
                if (!stop) begin
                    batch_q = batch_q[0:$urandom_range(0, batch_q.size() - 2)];
                end
            end
            BATCH_SHORT: begin
                batch_q = batch_q[0:$urandom_range(0, 22)];
            end
            BATCH_NOISE: begin
                batch_q.delete();
                push_rand($urandom_range(1, 40));
            end
            default: begin
            end
        endcase
    endtask

    function automatic t_batch_kind pick_kind(input int batch_no);
        int r;
        if (batch_no < 6) return t_batch_kind'(batch_no);
        r = $urandom_range(99);
        if (r < 45) return BATCH_GOOD;
        if (r < 57) return BATCH_BAD_CRC;
        if (r < 75) return BATCH_CUT;
        if (r < 82) return BATCH_SHORT;
        if (r < 93) return BATCH_NEG;
        return BATCH_NOISE;
    endfunction

    // Offer one item, idling first at the phase rate, and hold it until taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid              <= 1'b1;
        in_item.data_byte     <= b;
        in_item.end_of_data   <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_batch();
        foreach (batch_q[i]) begin
            send_byte(batch_q[i], i == batch_q.size() - 1);
        end
    endtask

    // Receiver: stall at the phase rate
    initial begin
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct());
        end
    end

    // Guard against a hung run
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        int batch_no;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_item    <= '0;
        bytes_sent = 0;
        batch_no   = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a lone end byte, then the smallest complete batch with extreme header
        batch_q = '{8'hFF};
        send_batch();
        batch_q.delete();
        push_le('1, 8);
        push_le('0, 8);
        push_le('0, 4);
        append_crc(1'b0);
        send_batch();

        // Random batches, every kind first, then weighted towards well-formed ones
        while (bytes_sent < ITEM_TARGET) begin
            build_batch(pick_kind(batch_no));
            send_batch();
            batch_no++;
        end
        in_valid <= 1'b0;

        // Drain outstanding results, then give stragglers time to show
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (chk_fails == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
